[rtl/dhss_pkg.sv]
// Shared types, constants and modular arithmetic helpers for the double hash substring search.
package dhss_pkg;

    // Default sizes, handed to the top level parameters
    localparam int MAX_PATTERN_DEF = 32;
    localparam int MAX_TEXT_DEF    = 65536;

    // Field and datapath widths
    localparam int LETTER_W    = 5;
    localparam int POS_W       = 16;
    localparam int HASH_W      = 30;
    localparam int PROD_W      = 35;
    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 24;

    // Input item queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // Hash constants
    localparam logic [HASH_W-1:0]   MOD_A   = 30'd1000000007;
    localparam logic [HASH_W-1:0]   MOD_B   = 30'd1000000033;
    localparam logic [LETTER_W-1:0] RADIX_A = 5'd26;
    localparam logic [LETTER_W-1:0] RADIX_B = 5'd27;
    localparam logic [POS_W-1:0]    POS_MAX = 16'hFFFF;

    // Item kinds, decided at the front
    typedef enum logic [1:0] {
        KIND_PAT_NEW,
        KIND_PAT_ADD,
        KIND_TXT_NEW,
        KIND_TXT_ADD
    } kind_t;

    // One queued item
    typedef struct packed {
        kind_t                kind;
        logic                 last;
        logic [LETTER_W-1:0]  letter;
    } cmd_t;

    // Fold table: largest multiple of the modulus not above idx * 2^27
    typedef logic [PROD_W-1:0] red_tbl_t [256];

    function automatic red_tbl_t build_red_tbl(input logic [HASH_W-1:0] modv);
        red_tbl_t    tbl;
        logic [63:0] base;
        logic [63:0] acc;
        logic [63:0] best;
        for (int i = 0; i < 256; i++)
        begin
            base = 64'(i) << 27;
            acc  = 64'd0;
            best = 64'd0;
            for (int k = 0; k < 40; k++)
            begin
                if (acc <= base)
                begin
                    best = acc;
                end
                acc = acc + 64'(modv);
            end
            tbl[i] = best[PROD_W-1:0];
        end
        return tbl;
    endfunction

    localparam red_tbl_t RED_TBL_A = build_red_tbl(MOD_A);
    localparam red_tbl_t RED_TBL_B = build_red_tbl(MOD_B);

    // Reduce a 35 bit product below the modulus; sel_b picks the second modulus
    function automatic logic [HASH_W-1:0] mod_fold(input logic [PROD_W-1:0] t,
                                                   input logic sel_b);
        logic [PROD_W-1:0] diff;
        logic [HASH_W:0]   r;
        logic [HASH_W:0]   m;
        m    = {1'b0, (sel_b ? MOD_B : MOD_A)};
        diff = t - (sel_b ? RED_TBL_B[t[PROD_W-1:27]] : RED_TBL_A[t[PROD_W-1:27]]);
        r    = diff[HASH_W:0];
        if (r >= m)
        begin
            r = r - m;
        end
        return r[HASH_W-1:0];
    endfunction

    // (x + y) mod p for x, y below p
    function automatic logic [HASH_W-1:0] mod_add(input logic [HASH_W-1:0] x,
                                                  input logic [HASH_W-1:0] y,
                                                  input logic sel_b);
        logic [HASH_W:0] s;
        logic [HASH_W:0] m;
        m = {1'b0, (sel_b ? MOD_B : MOD_A)};
        s = {1'b0, x} + {1'b0, y};
        if (s >= m)
        begin
            s = s - m;
        end
        return s[HASH_W-1:0];
    endfunction

    // (p - s) mod p for s below p
    function automatic logic [HASH_W-1:0] mod_neg(input logic [HASH_W-1:0] s,
                                                  input logic sel_b);
        logic [HASH_W-1:0] m;
        m = sel_b ? MOD_B : MOD_A;
        return (s == '0) ? '0 : (m - s);
    endfunction

    // (h * radix) mod p for h below p
    function automatic logic [HASH_W-1:0] mod_mul_radix(input logic [HASH_W-1:0] h,
                                                        input logic sel_b);
        logic [PROD_W-1:0] t;
        t = {5'd0, h} * PROD_W'(sel_b ? RADIX_B : RADIX_A);
        return mod_fold(t, sel_b);
    endfunction

endpackage

[rtl/double_hash_substring_search_top.sv]
// Top level of the double hash substring search: front queue and back hashing pipeline.
//
//  channel  | dir | tdata                    | tuser               | tlast
//  s_axis   | in  | [4:0] letter             | [0] opcode [1] first | last
//  m_axis   | out | [0] found [16:1] position | -                   | -
//
//  One item per cycle sustained while no result is stalled.
//  The rate is set by the window hash recurrence: one multiply by radix, fold and
//  modular add per cycle in the third back stage.
//  Reset clears all control state at once; the letter ring needs no clearing.
//  A stalled result freezes the back part; the four entry queue keeps taking items until full.
module double_hash_substring_search_top #(
    parameter int MAX_PATTERN = dhss_pkg::MAX_PATTERN_DEF,
    parameter int MAX_TEXT    = dhss_pkg::MAX_TEXT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [dhss_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [4:0] letter, rest zero
    input  logic [dhss_pkg::IN_TUSER_W-1:0]  s_axis_tuser,  // [0] opcode, [1] first
    input  logic                             s_axis_tlast,  // last
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [dhss_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // [0] found, [16:1] position
);
    import dhss_pkg::*;

    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    dhss_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop)
    );

    dhss_back #(
        .MAX_PATTERN(MAX_PATTERN),
        .MAX_TEXT   (MAX_TEXT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

endmodule

[rtl/dhss_ram.sv]
// Generic single write port, single read port RAM with registered read (read-first).
module dhss_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read; a read at the written address returns the old entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/dhss_front.sv]
// Front part: accepts input items, classifies them and queues them for the back part.
module dhss_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [dhss_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // [4:0] letter, rest zero
    input  logic [dhss_pkg::IN_TUSER_W-1:0] s_axis_tuser,  // [0] opcode, [1] first
    input  logic                            s_axis_tlast,  // last
    output logic                            q_valid,
    output dhss_pkg::cmd_t                  q_cmd,
    input  logic                            q_pop
);
    import dhss_pkg::*;

    cmd_t            q_mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_next;
    logic [Q_AW:0]   cnt_reg;
    logic [Q_AW:0]   cnt_next;
    logic            push;
    logic            pop;
    cmd_t            cmd_in;
    logic            opcode;
    logic            first;

    // classify the incoming item
    assign opcode = s_axis_tuser[0];
    assign first  = s_axis_tuser[1];

    always_comb
    begin
        cmd_in.letter = s_axis_tdata[LETTER_W-1:0];
        cmd_in.last   = s_axis_tlast & opcode;
        if (opcode)
        begin
            cmd_in.kind = first ? KIND_TXT_NEW : KIND_TXT_ADD;
        end
        else
        begin
            cmd_in.kind = first ? KIND_PAT_NEW : KIND_PAT_ADD;
        end
    end

    // queue handshakes
    assign s_axis_tready = (cnt_reg != (Q_AW+1)'(Q_DEPTH));
    assign q_valid       = (cnt_reg != '0);
    assign q_cmd         = q_mem_reg[rd_ptr_reg];
    assign push          = s_axis_tvalid & s_axis_tready;
    assign pop           = q_pop & q_valid;

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

[rtl/dhss_back.sv]
// Back part: pattern hashing, text window bookkeeping, rolling hash pipeline and result register.
module dhss_back #(
    parameter int MAX_PATTERN = dhss_pkg::MAX_PATTERN_DEF,
    parameter int MAX_TEXT    = dhss_pkg::MAX_TEXT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_valid,
    input  dhss_pkg::cmd_t                   q_cmd,
    output logic                             q_pop,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [dhss_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import dhss_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int AW    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CNT_W = $clog2(MAX_TEXT + 1);
    localparam int IW    = LEN_W + 1;
    localparam int CW0   = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int CW    = (CW0 > POS_W) ? CW0 : POS_W + 1;

    // item travelling down the back pipeline
    typedef struct packed {
        logic                 text;
        logic                 first;
        logic                 last;
        logic                 roll;
        logic                 ge;
        logic                 len_zero;
        logic [POS_W-1:0]     pos;
        logic [LETTER_W-1:0]  letter;
        logic [HASH_W-1:0]    ph_a;
        logic [HASH_W-1:0]    ph_b;
    } item_t;

    // pattern state
    logic [HASH_W-1:0] pat_hash_a_reg, pat_hash_a_next;
    logic [HASH_W-1:0] pat_hash_b_reg, pat_hash_b_next;
    logic [HASH_W-1:0] pow_a_reg, pow_a_next;
    logic [HASH_W-1:0] pow_b_reg, pow_b_next;
    logic [LEN_W-1:0]  pat_len_reg, pat_len_next;

    // text state
    logic [AW-1:0]     wp_reg, wp_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [HASH_W-1:0] win_a_reg, win_a_next;
    logic [HASH_W-1:0] win_b_reg, win_b_next;
    logic              reported_reg, reported_next;

    // pipeline registers
    logic              b1_valid_reg, b2_valid_reg, b3_valid_reg, b4_valid_reg;
    item_t             b1_reg, b2_reg, b3_reg, b4_reg;
    item_t             b0_item;
    logic [HASH_W-1:0] b1_pow_a_reg, b1_pow_b_reg;
    logic [PROD_W-1:0] b2_prod_a_reg, b2_prod_b_reg;
    logic [HASH_W-1:0] b3_u_a_reg, b3_u_b_reg;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic              out_found_reg, out_found_next;
    logic [POS_W-1:0]  out_pos_reg, out_pos_next;

    logic              adv;
    logic              pop;
    logic              is_text;
    logic              is_first;
    logic [LEN_W-1:0]  len_base;
    logic [HASH_W-1:0] ph_a_base, ph_b_base, pw_a_base, pw_b_base;
    logic [CNT_W-1:0]  cnt_base, cnt_after;
    logic [AW-1:0]     wp_base, wp_after, rd_idx;
    logic [IW-1:0]     wp_ext, len_ext, idx_wide;
    logic [CW-1:0]     cnt_base_cw, cnt_after_cw, len_cw, diff_cw;
    logic [LETTER_W-1:0] ram_rdata, drop;
    logic [HASH_W-1:0] s_a, s_b, u_a, u_b, h_a_base, h_b_base;
    logic              match;

    // the whole back part moves when the result register can take a new value
    assign adv   = !out_valid_reg || m_axis_tready;
    assign pop   = adv && q_valid;
    assign q_pop = adv;

    // item kind decode
    always_comb
    begin
        is_text  = 1'b0;
        is_first = 1'b0;
        unique case (q_cmd.kind)
            KIND_PAT_NEW:
            begin
                is_first = 1'b1;
            end
            KIND_PAT_ADD:
            begin
                is_first = 1'b0;
            end
            KIND_TXT_NEW:
            begin
                is_text  = 1'b1;
                is_first = 1'b1;
            end
            KIND_TXT_ADD:
            begin
                is_text  = 1'b1;
            end
            default:
            begin
                is_text  = 1'b0;
                is_first = 1'b0;
            end
        endcase
    end

    // pattern hash and radix power update
    always_comb
    begin
        ph_a_base = is_first ? '0 : pat_hash_a_reg;
        ph_b_base = is_first ? '0 : pat_hash_b_reg;
        pw_a_base = is_first ? HASH_W'(1) : pow_a_reg;
        pw_b_base = is_first ? HASH_W'(1) : pow_b_reg;
        len_base  = is_first ? '0 : pat_len_reg;
        pat_hash_a_next = ph_a_base;
        pat_hash_b_next = ph_b_base;
        pow_a_next      = pw_a_base;
        pow_b_next      = pw_b_base;
        pat_len_next    = len_base;
        if (len_base < LEN_W'(MAX_PATTERN))
        begin
            pat_hash_a_next = mod_add(mod_mul_radix(ph_a_base, 1'b0),
                                      HASH_W'(q_cmd.letter), 1'b0);
            pat_hash_b_next = mod_add(mod_mul_radix(ph_b_base, 1'b1),
                                      HASH_W'(q_cmd.letter), 1'b1);
            pow_a_next      = mod_mul_radix(pw_a_base, 1'b0);
            pow_b_next      = mod_mul_radix(pw_b_base, 1'b1);
            pat_len_next    = len_base + 1'b1;
        end
    end

    // text count, ring pointer and the ring slot of the outgoing letter
    always_comb
    begin
        cnt_base     = is_first ? '0 : cnt_reg;
        wp_base      = is_first ? '0 : wp_reg;
        cnt_after    = (cnt_base < CNT_W'(MAX_TEXT)) ? cnt_base + 1'b1 : cnt_base;
        wp_after     = (wp_base == AW'(MAX_PATTERN - 1)) ? '0 : wp_base + 1'b1;
        cnt_base_cw  = CW'(cnt_base);
        cnt_after_cw = CW'(cnt_after);
        len_cw       = CW'(pat_len_reg);
        diff_cw      = cnt_after_cw - len_cw;
        wp_ext       = IW'(wp_base);
        len_ext      = IW'(pat_len_reg);
        if (wp_ext >= len_ext)
        begin
            idx_wide = wp_ext - len_ext;
        end
        else
        begin
            idx_wide = wp_ext + IW'(MAX_PATTERN) - len_ext;
        end
        rd_idx   = idx_wide[AW-1:0];
        cnt_next = is_text ? cnt_after : cnt_reg;
        wp_next  = is_text ? wp_after : wp_reg;
    end

    // item entering the pipeline
    always_comb
    begin
        b0_item.text     = is_text;
        b0_item.first    = is_first;
        b0_item.last     = q_cmd.last;
        b0_item.roll     = (cnt_base_cw >= len_cw);
        b0_item.ge       = (cnt_after_cw >= len_cw);
        b0_item.len_zero = (pat_len_reg == '0);
        b0_item.pos      = (diff_cw > CW'(POS_MAX)) ? POS_MAX : diff_cw[POS_W-1:0];
        b0_item.letter   = q_cmd.letter;
        b0_item.ph_a     = pat_hash_a_reg;
        b0_item.ph_b     = pat_hash_b_reg;
    end

    // ring of recent text letters
    dhss_ram #(
        .WIDTH(LETTER_W),
        .DEPTH(MAX_PATTERN)
    ) u_ring (
        .clk  (clk),
        .we   (pop && is_text),
        .waddr(wp_base),
        .wdata(q_cmd.letter),
        .re   (adv),
        .raddr(rd_idx),
        .rdata(ram_rdata)
    );

    // stage 1: outgoing letter times radix power
    assign drop = b1_reg.roll ? ram_rdata : '0;

    // stage 2: fold, negate and add the incoming letter
    always_comb
    begin
        s_a = mod_fold(b2_prod_a_reg, 1'b0);
        s_b = mod_fold(b2_prod_b_reg, 1'b1);
        u_a = mod_add(mod_neg(s_a, 1'b0), HASH_W'(b2_reg.letter), 1'b0);
        u_b = mod_add(mod_neg(s_b, 1'b1), HASH_W'(b2_reg.letter), 1'b1);
    end

    // stage 3: window hash recurrence
    always_comb
    begin
        h_a_base   = b3_reg.first ? '0 : win_a_reg;
        h_b_base   = b3_reg.first ? '0 : win_b_reg;
        win_a_next = win_a_reg;
        win_b_next = win_b_reg;
        if (b3_valid_reg && b3_reg.text)
        begin
            win_a_next = mod_add(mod_mul_radix(h_a_base, 1'b0), b3_u_a_reg, 1'b0);
            win_b_next = mod_add(mod_mul_radix(h_b_base, 1'b1), b3_u_b_reg, 1'b1);
        end
    end

    // stage 4: compare and decide the result
    assign match = (win_a_reg == b4_reg.ph_a) && (win_b_reg == b4_reg.ph_b);

    always_comb
    begin
        reported_next  = reported_reg;
        out_valid_next = 1'b0;
        out_found_next = 1'b0;
        out_pos_next   = '0;
        if (b4_valid_reg)
        begin
            if (!b4_reg.text)
            begin
                reported_next = 1'b1;
            end
            else if (b4_reg.first || !reported_reg)
            begin
                reported_next = 1'b0;
                if (b4_reg.len_zero)
                begin
                    reported_next  = 1'b1;
                    out_valid_next = 1'b1;
                    out_found_next = 1'b1;
                end
                else if (b4_reg.ge && match)
                begin
                    reported_next  = 1'b1;
                    out_valid_next = 1'b1;
                    out_found_next = 1'b1;
                    out_pos_next   = b4_reg.pos;
                end
                else if (b4_reg.last)
                begin
                    reported_next  = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_hash_a_reg <= '0;
            pat_hash_b_reg <= '0;
            pow_a_reg      <= HASH_W'(1);
            pow_b_reg      <= HASH_W'(1);
            pat_len_reg    <= '0;
            wp_reg         <= '0;
            cnt_reg        <= '0;
            win_a_reg      <= '0;
            win_b_reg      <= '0;
            reported_reg   <= 1'b0;
            b1_valid_reg   <= 1'b0;
            b2_valid_reg   <= 1'b0;
            b3_valid_reg   <= 1'b0;
            b4_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            if (q_valid && !is_text)
            begin
                pat_hash_a_reg <= pat_hash_a_next;
                pat_hash_b_reg <= pat_hash_b_next;
                pow_a_reg      <= pow_a_next;
                pow_b_reg      <= pow_b_next;
                pat_len_reg    <= pat_len_next;
            end
            if (q_valid)
            begin
                wp_reg  <= wp_next;
                cnt_reg <= cnt_next;
            end
            win_a_reg     <= win_a_next;
            win_b_reg     <= win_b_next;
            reported_reg  <= reported_next;
            b1_valid_reg  <= q_valid;
            b2_valid_reg  <= b1_valid_reg;
            b3_valid_reg  <= b2_valid_reg;
            b4_valid_reg  <= b3_valid_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_reg        <= b0_item;
            b1_pow_a_reg  <= pow_a_reg;
            b1_pow_b_reg  <= pow_b_reg;
            b2_reg        <= b1_reg;
            b2_prod_a_reg <= {30'd0, drop} * {5'd0, b1_pow_a_reg};
            b2_prod_b_reg <= {30'd0, drop} * {5'd0, b1_pow_b_reg};
            b3_reg        <= b2_reg;
            b3_u_a_reg    <= u_a;
            b3_u_b_reg    <= u_b;
            b4_reg        <= b3_reg;
            out_found_reg <= out_found_next;
            out_pos_reg   <= out_pos_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - POS_W - 1)'(0), out_pos_reg, out_found_reg};

endmodule

[rtl/dhss_checker.sv]
// Port level checks for the double hash substring search, bound to the top level.
module dhss_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [dhss_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic [dhss_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    input logic                             s_axis_tlast,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [dhss_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // a held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a held result keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // the queue only fills up behind a stalled result
    a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input blocked without an output stall");

    // the queue frees up only when the back part moved
    a_free_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s_axis_tready) |-> $past(!m_axis_tvalid || m_axis_tready))
        else $error("input reopened while output stalled");

endmodule

bind double_hash_substring_search_top dhss_checker u_dhss_checker (.*);

[sim/double_hash_substring_search_top_tb.sv]
// Self-checking testbench for the double hash substring search: predicts every result of a stream.
module double_hash_substring_search_top_tb;

    localparam int              MAX_PAT     = dhss_pkg::MAX_PATTERN_DEF;
    localparam int              MAX_TXT     = dhss_pkg::MAX_TEXT_DEF;
    localparam longint unsigned HASH_MOD_A  = 64'd1000000007;
    localparam longint unsigned HASH_MOD_B  = 64'd1000000033;
    localparam longint unsigned HASH_RAD_A  = 64'd26;
    localparam longint unsigned HASH_RAD_B  = 64'd27;
    localparam int unsigned     POS_LIMIT   = 65535;
    localparam int              ITEM_TARGET = 530;
    localparam int              STALL_LIMIT = 1000;
    localparam int              HOLD_CYCLES = 80;
    localparam int              HOLD_AFTER  = 150;
    localparam int              TAIL_CYCLES = 20;

    typedef enum bit {
        OP_PATTERN,
        OP_TEXT
    } op_t;

    // One stream item plus a marker that makes the sender wait for all results
    typedef struct packed {
        op_t        op;
        logic [4:0] letter;
        logic       first;
        logic       last;
        logic       drain;
    } stim_t;

    typedef struct packed {
        logic        found;
        logic [15:0] position;
    } match_t;

    logic                              clk;
    logic                              rst_n;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [dhss_pkg::IN_TDATA_W-1:0]   s_axis_tdata;
    logic [dhss_pkg::IN_TUSER_W-1:0]   s_axis_tuser;
    logic                              s_axis_tlast;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [dhss_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;

    // Rabin-Karp predictor with its own copy of the block state
    class match_scoreboard;
        logic [29:0] pat_ha;
        logic [29:0] pat_hb;
        logic [29:0] pow_a;
        logic [29:0] pow_b;
        int unsigned pat_len;
        logic [29:0] win_ha;
        logic [29:0] win_hb;
        logic [4:0]  ring [MAX_PAT];
        int unsigned wr_ptr;
        int unsigned txt_cnt;
        bit          done;
        match_t      expected_q [$];
        int unsigned errors;

        function new();
            pat_ha  = '0;
            pat_hb  = '0;
            pow_a   = 30'd1;
            pow_b   = 30'd1;
            pat_len = 0;
            win_ha  = '0;
            win_hb  = '0;
            wr_ptr  = 0;
            txt_cnt = 0;
            done    = 0;
            errors  = 0;
            foreach (ring[i])
            begin
                ring[i] = '0;
            end
        endfunction

        // (h * radix + add) mod m
        function logic [29:0] shift_in(logic [29:0] h, longint unsigned radix,
                                       longint unsigned modv, logic [4:0] add);
            longint unsigned t;
            t = h;
            t = (t * radix) % modv;
            t = (t + add) % modv;
            return t[29:0];
        endfunction

        // (h * radix - drop * power + add) mod m
        function logic [29:0] roll_out(logic [29:0] h, longint unsigned radix,
                                       longint unsigned modv, logic [29:0] power,
                                       logic [4:0] drop, logic [4:0] add);
            longint unsigned t;
            longint unsigned s;
            t = h;
            t = (t * radix) % modv;
            s = drop;
            s = (s * power) % modv;
            t = (t + modv - s + add) % modv;
            return t[29:0];
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(op_t op, logic [4:0] ltr, logic first, logic last);
            int unsigned slot;
            int unsigned pos;
            match_t      res;
            if (op == OP_PATTERN)
            begin
                if (first)
                begin
                    pat_ha  = '0;
                    pat_hb  = '0;
                    pow_a   = 30'd1;
                    pow_b   = 30'd1;
                    pat_len = 0;
                end
                // letters past the pattern limit are dropped
                if (pat_len < MAX_PAT)
                begin
                    pat_ha = shift_in(pat_ha, HASH_RAD_A, HASH_MOD_A, ltr);
                    pat_hb = shift_in(pat_hb, HASH_RAD_B, HASH_MOD_B, ltr);
                    pow_a  = shift_in(pow_a, HASH_RAD_A, HASH_MOD_A, 5'd0);
                    pow_b  = shift_in(pow_b, HASH_RAD_B, HASH_MOD_B, 5'd0);
                    pat_len++;
                end
                done = 1;
                return;
            end
            if (first)
            begin
                win_ha  = '0;
                win_hb  = '0;
                txt_cnt = 0;
                wr_ptr  = 0;
                done    = 0;
            end
            if (done)
            begin
                return;
            end
            // empty pattern matches right away
            if (pat_len == 0)
            begin
                done = 1;
                res.found    = 1'b1;
                res.position = 16'd0;
                expected_q.insert(expected_q.size(), res);
                return;
            end
            if (txt_cnt < pat_len)
            begin
                win_ha = shift_in(win_ha, HASH_RAD_A, HASH_MOD_A, ltr);
                win_hb = shift_in(win_hb, HASH_RAD_B, HASH_MOD_B, ltr);
            end
            else
            begin
                slot   = (wr_ptr >= pat_len) ? wr_ptr - pat_len : wr_ptr + MAX_PAT - pat_len;
                win_ha = roll_out(win_ha, HASH_RAD_A, HASH_MOD_A, pow_a, ring[slot], ltr);
                win_hb = roll_out(win_hb, HASH_RAD_B, HASH_MOD_B, pow_b, ring[slot], ltr);
            end
            ring[wr_ptr] = ltr;
            wr_ptr = (wr_ptr + 1) % MAX_PAT;
            if (txt_cnt < MAX_TXT)
            begin
                txt_cnt++;
            end
            if (txt_cnt >= pat_len && win_ha == pat_ha && win_hb == pat_hb)
            begin
                pos = txt_cnt - pat_len;
                if (pos > POS_LIMIT)
                begin
                    pos = POS_LIMIT;
                end
                done = 1;
                res.found    = 1'b1;
                res.position = pos[15:0];
                expected_q.insert(expected_q.size(), res);
                return;
            end
            if (last)
            begin
                done = 1;
                res.found    = 1'b0;
                res.position = 16'd0;
                expected_q.insert(expected_q.size(), res);
            end
        endfunction

        function void check_result(logic found, logic [15:0] position);
            match_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected, found %0b position %0d",
                         $time, found, position);
                return;
            end
            want = expected_q.pop_front();
            if (found !== want.found)
            begin
                errors++;
                $display("%0t: found expected %0b actual %0b", $time, want.found, found);
            end
            if (position !== want.position)
            begin
                errors++;
                $display("%0t: position expected %0d actual %0d",
                         $time, want.position, position);
            end
        endfunction
    endclass

    match_scoreboard sb;
    stim_t           stim_q [$];
    logic [4:0]      pat_letters [$];
    bit              pat_known;
    bit              hold_on;
    int              accepted_in;
    int              idle_cycles;
    int              directed_len;

    double_hash_substring_search_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    function automatic logic [4:0] pick_letter(int alpha);
        if ($urandom_range(0, 9) == 0)
        begin
            return 5'($urandom_range(0, 31));
        end
        return 5'($urandom_range(0, alpha - 1));
    endfunction

    task automatic push_item(op_t op, int ltr, bit first, bit last);
        stim_t it;
        it.op     = op;
        it.letter = 5'(ltr);
        it.first  = first;
        it.last   = last;
        it.drain  = 1'b0;
        stim_q.insert(stim_q.size(), it);
    endtask

    // Hand-picked corner cases
    task automatic build_directed();
        // empty pattern right after reset, then a letter after the result
        push_item(OP_TEXT, 0, 0, 0);
        push_item(OP_TEXT, 31, 0, 1);
        // pattern "za", last on a pattern letter has no effect
        push_item(OP_PATTERN, 25, 1, 1);
        push_item(OP_PATTERN, 0, 0, 0);
        push_item(OP_TEXT, 3, 1, 0);
        push_item(OP_TEXT, 25, 0, 0);
        push_item(OP_TEXT, 0, 0, 0);
        push_item(OP_TEXT, 7, 0, 1);
        // one-letter text shorter than the pattern
        push_item(OP_TEXT, 25, 1, 1);
        // codes above z in pattern and text
        push_item(OP_PATTERN, 31, 1, 0);
        push_item(OP_PATTERN, 26, 0, 0);
        push_item(OP_TEXT, 30, 1, 0);
        push_item(OP_TEXT, 31, 0, 0);
        push_item(OP_TEXT, 26, 0, 0);
        push_item(OP_TEXT, 31, 0, 1);
        // pattern letter abandons the text in progress
        push_item(OP_TEXT, 1, 1, 0);
        push_item(OP_TEXT, 2, 0, 0);
        push_item(OP_PATTERN, 4, 0, 0);
        push_item(OP_TEXT, 31, 0, 0);
        push_item(OP_TEXT, 26, 0, 1);
        push_item(OP_TEXT, 31, 1, 0);
        push_item(OP_TEXT, 26, 0, 0);
        push_item(OP_TEXT, 4, 0, 1);
        // text without a match
        push_item(OP_TEXT, 0, 1, 0);
        push_item(OP_TEXT, 0, 0, 1);
        pat_letters = '{5'd31, 5'd26, 5'd4};
        pat_known   = 1;
    endtask

    // Mostly well-formed pattern and text runs, some broken runs and noise
    task automatic build_random();
        int         kind;
        int         plen;
        int         eff;
        int         tlen;
        int         off;
        int         alpha;
        bit         hit;
        logic [4:0] txt [$];
        while (stim_q.size() < ITEM_TARGET)
        begin
            kind  = $urandom_range(0, 99);
            alpha = ($urandom_range(0, 1) == 0) ? $urandom_range(2, 4) : $urandom_range(2, 26);
            if (kind < 75)
            begin
                if (!pat_known || $urandom_range(0, 2) == 0)
                begin
                    plen = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36)
                                                       : $urandom_range(1, 6);
                    pat_letters.delete();
                    for (int i = 0; i < plen; i++)
                    begin
                        pat_letters.insert(pat_letters.size(), pick_letter(alpha));
                        push_item(OP_PATTERN, pat_letters[i], i == 0,
                                  $urandom_range(0, 7) == 0);
                    end
                    pat_known = 1;
                end
                eff = (pat_letters.size() > MAX_PAT) ? MAX_PAT : pat_letters.size();
                hit = ($urandom_range(0, 9) < 7);
                tlen = hit ? $urandom_range(eff, eff + 30) : $urandom_range(1, 40);
                txt.delete();
                for (int i = 0; i < tlen; i++)
                begin
                    txt.insert(txt.size(), pick_letter(alpha));
                end
                if (hit)
                begin
                    off = $urandom_range(0, tlen - eff);
                    for (int i = 0; i < eff; i++)
                    begin
                        txt[off + i] = pat_letters[i];
                    end
                end
                for (int i = 0; i < tlen; i++)
                begin
                    push_item(OP_TEXT, txt[i], i == 0,
                              (i == tlen - 1) && ($urandom_range(0, 9) != 0));
                end
                // stray letters after the result
                if ($urandom_range(0, 3) == 0)
                begin
                    repeat ($urandom_range(1, 3))
                    begin
                        push_item(OP_TEXT, pick_letter(alpha), 0, 1'($urandom_range(0, 1)));
                    end
                end
            end
            else if (kind < 88)
            begin
                // text cut short by a pattern letter
                repeat ($urandom_range(1, 5))
                begin
                    push_item(OP_TEXT, pick_letter(alpha), 0, 0);
                end
                stim_q[stim_q.size() - 1].first = 1'b0;
                if ($urandom_range(0, 1) == 0)
                begin
                    pat_letters.delete();
                    pat_letters.insert(pat_letters.size(), pick_letter(alpha));
                    push_item(OP_PATTERN, pat_letters[0], 1, 0);
                end
                else
                begin
                    pat_letters.insert(pat_letters.size(), pick_letter(alpha));
                    push_item(OP_PATTERN, pat_letters[pat_letters.size() - 1], 0, 0);
                end
                repeat ($urandom_range(0, 3))
                begin
                    push_item(OP_TEXT, pick_letter(alpha), 0, 1'($urandom_range(0, 1)));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    push_item(op_t'($urandom_range(0, 1)), int'($urandom_range(0, 31)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
                pat_known = 0;
            end
        end
    endtask

    // Drive one item from a falling edge until it is taken
    task automatic send_item(stim_t it);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, it.letter};
        s_axis_tuser  <= {it.first, it.op};
        s_axis_tlast  <= it.last;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Sender
    initial
    begin
        stim_t it;
        int    burst_left;
        sb            = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        burst_left    = 0;
        build_directed();
        directed_len = stim_q.size();
        build_random();
        stim_q[directed_len].drain = 1'b1;
        stim_q[directed_len + 250].drain = 1'b1;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        while (stim_q.size() > 0)
        begin
            it = stim_q.pop_front();
            if (it.drain)
            begin
                // wait out every outstanding result
                s_axis_tvalid <= 1'b0;
                @(negedge clk);
                while (sb.pending() != 0)
                begin
                    @(negedge clk);
                end
            end
            else if (burst_left == 0 && !hold_on)
            begin
                burst_left = $urandom_range(1, 30);
                if ($urandom_range(0, 3) != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(negedge clk);
                end
            end
            send_item(it);
            if (burst_left > 0)
            begin
                burst_left--;
            end
        end
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (TAIL_CYCLES) @(negedge clk);
        if (sb.errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Receiver: changing stall patterns and one long hold-off
    initial
    begin
        int  cyc;
        int  mode;
        bit  hold_done;
        cyc           = 0;
        mode          = 0;
        hold_done     = 0;
        hold_on       = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            cyc++;
            if (!hold_done && accepted_in >= HOLD_AFTER)
            begin
                hold_on       = 1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_on   = 0;
                hold_done = 1;
            end
            else
            begin
                if (cyc % 37 == 0)
                begin
                    mode = $urandom_range(0, 3);
                end
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= (cyc % 7 < 5);
                endcase
            end
        end
    end

    // Monitor and watchdog
    initial
    begin
        accepted_in = 0;
        idle_cycles = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                sb.note_input(op_t'(s_axis_tuser[0]), s_axis_tdata[4:0],
                              s_axis_tuser[1], s_axis_tlast);
                accepted_in++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                sb.check_result(m_axis_tdata[0], m_axis_tdata[16:1]);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: timeout, %0d results outstanding", $time, sb.pending());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

endmodule

[filelist.f]
rtl/dhss_pkg.sv
rtl/dhss_ram.sv
rtl/dhss_front.sv
rtl/dhss_back.sv
rtl/double_hash_substring_search_top.sv
rtl/dhss_checker.sv
sim/double_hash_substring_search_top_tb.sv
